>>> hw/rtl/kcst_pkg.sv
// kcst_pkg: shared types, codes and sizing for the keyed context slot table.
// Used by kcst_front, kcst_queue, kcst_back and keyed_context_slot_table.
// No dependencies.
package kcst_pkg;

    // table sizing
    localparam int SLOTS   = 8;
    localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int KEY_W   = 64;
    localparam int VAL_W   = 64;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;
    localparam int CFG_W   = 4;
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(8);

    // command codes
    localparam logic [CMD_W-1:0] CMD_SET = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GET = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DEL = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RSV = 2'd3;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD  = 2'd2;

    // classified request, front to back
    typedef struct packed {
        logic             bad;
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] wval;
    } t_item;

    // back-end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_EXEC
    } t_back_state;

    // number of slots that take part in a search, saturated at SLOTS
    function automatic logic [CNT_W-1:0] live_count(input logic [CFG_W-1:0] active);
        logic [CNT_W-1:0] n;
        if (int'(active) > SLOTS) begin
            n = CNT_W'(SLOTS);
        end else begin
            n = CNT_W'(active);
        end
        return n;
    endfunction

endpackage

>>> hw/rtl/kcst_front.sv
// kcst_front: accepts requests, flags invalid ones, holds one in a register.
// Pushes into kcst_queue; uses kcst_pkg.
module kcst_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [kcst_pkg::CMD_W-1:0] i_cmd,
    input  logic [kcst_pkg::KEY_W-1:0] i_key,
    input  logic [kcst_pkg::VAL_W-1:0] i_write_value,
    input  logic                       i_q_full,
    output logic                       o_q_push,
    output kcst_pkg::t_item            o_q_data
);

    logic            r_valid;
    kcst_pkg::t_item r_item;
    logic            accept;

    // hold a request only while the queue cannot take the one in hand
    assign busy     = r_valid & i_q_full;
    assign accept   = start & ~busy;
    assign o_q_push = r_valid & ~i_q_full;
    assign o_q_data = r_item;

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_q_push) begin
            r_valid <= 1'b0;
        end
    end

    // classify: zero key or the unused command code is rejected
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.bad  <= (i_key == '0) || (i_cmd == kcst_pkg::CMD_RSV);
            r_item.cmd  <= i_cmd;
            r_item.key  <= i_key;
            r_item.wval <= i_write_value;
        end
    end

endmodule

>>> hw/rtl/kcst_queue.sv
// kcst_queue: short FIFO of classified requests between front and back.
// Uses kcst_pkg for the item type and depth.
module kcst_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  kcst_pkg::t_item i_push_data,
    output logic            o_full,
    input  logic            i_pop,
    output kcst_pkg::t_item o_pop_data,
    output logic            o_empty
);

    kcst_pkg::t_item                 r_mem [kcst_pkg::Q_DEPTH];
    logic [kcst_pkg::Q_PTR_W-1:0]    r_wr_ptr;
    logic [kcst_pkg::Q_PTR_W-1:0]    r_rd_ptr;
    logic [kcst_pkg::Q_CNT_W-1:0]    r_count;
    logic                            do_push;
    logic                            do_pop;

    assign o_full     = (r_count == kcst_pkg::Q_CNT_W'(kcst_pkg::Q_DEPTH));
    assign o_empty    = (r_count == '0);
    assign do_push    = i_push & ~o_full;
    assign do_pop     = i_pop & ~o_empty;
    assign o_pop_data = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

>>> hw/rtl/kcst_back.sv
// kcst_back: slot store and the sequencer that scans it one slot per cycle.
// Pops from kcst_queue; uses kcst_pkg.
module kcst_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [kcst_pkg::CFG_W-1:0]  i_active,
    input  logic                        i_q_empty,
    input  kcst_pkg::t_item             i_q_data,
    output logic                        o_q_pop,
    output logic                        o_result_valid,
    output logic [kcst_pkg::STAT_W-1:0] o_status,
    output logic [kcst_pkg::VAL_W-1:0]  o_read_value
);

    kcst_pkg::t_back_state r_state, n_state;

    logic [kcst_pkg::KEY_W-1:0]  r_slot_key   [kcst_pkg::SLOTS];
    logic [kcst_pkg::VAL_W-1:0]  r_slot_value [kcst_pkg::SLOTS];

    kcst_pkg::t_item             r_cur, n_cur;
    logic [kcst_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic                        r_hit, n_hit;
    logic [kcst_pkg::IDX_W-1:0]  r_hit_idx, n_hit_idx;
    logic                        r_free, n_free;
    logic [kcst_pkg::IDX_W-1:0]  r_free_idx, n_free_idx;

    logic                        r_out_valid, n_out_valid;
    logic [kcst_pkg::STAT_W-1:0] r_status, n_status;
    logic [kcst_pkg::VAL_W-1:0]  r_rval, n_rval;

    logic [kcst_pkg::CNT_W-1:0]  live;
    logic [kcst_pkg::IDX_W-1:0]  scan_idx;
    logic [kcst_pkg::KEY_W-1:0]  scan_key;
    logic [kcst_pkg::IDX_W-1:0]  target;

    logic                        wr_en;
    logic [kcst_pkg::IDX_W-1:0]  wr_idx;
    logic [kcst_pkg::KEY_W-1:0]  wr_key;
    logic [kcst_pkg::VAL_W-1:0]  wr_val;

    assign live     = kcst_pkg::live_count(i_active);
    assign scan_idx = r_cnt[kcst_pkg::IDX_W-1:0];
    assign scan_key = r_slot_key[scan_idx];
    assign target   = r_hit ? r_hit_idx : r_free_idx;

    assign o_result_valid = r_out_valid;
    assign o_status       = r_status;
    assign o_read_value   = r_rval;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kcst_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // working registers and result payload
    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_cnt      <= n_cnt;
        r_hit      <= n_hit;
        r_hit_idx  <= n_hit_idx;
        r_free     <= n_free;
        r_free_idx <= n_free_idx;
        r_status   <= n_status;
        r_rval     <= n_rval;
    end

    // slot store: keys cleared at reset mean every slot starts empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < kcst_pkg::SLOTS; i++) begin
                r_slot_key[i] <= '0;
            end
        end else if (wr_en) begin
            r_slot_key[wr_idx] <= wr_key;
        end
    end

    // values are only read behind a key match, so they need no reset
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_slot_value[wr_idx] <= wr_val;
        end
    end

    // sequencer: next state, scan bookkeeping, execute, result
    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_cnt       = r_cnt;
        n_hit       = r_hit;
        n_hit_idx   = r_hit_idx;
        n_free      = r_free;
        n_free_idx  = r_free_idx;
        n_out_valid = 1'b0;
        n_status    = r_status;
        n_rval      = r_rval;
        o_q_pop     = 1'b0;
        wr_en       = 1'b0;
        wr_idx      = target;
        wr_key      = '0;
        wr_val      = '0;

        unique case (r_state)
            kcst_pkg::BK_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_cur   = i_q_data;
                    if (i_q_data.bad) begin
                        // rejected request answers at once
                        n_out_valid = 1'b1;
                        n_status    = kcst_pkg::ST_BAD;
                        n_rval      = '0;
                    end else begin
                        n_cnt   = '0;
                        n_hit   = 1'b0;
                        n_free  = 1'b0;
                        n_state = kcst_pkg::BK_SCAN;
                    end
                end
            end

            kcst_pkg::BK_SCAN: begin
                if (r_cnt >= live) begin
                    n_state = kcst_pkg::BK_EXEC;
                end else if (scan_key == r_cur.key) begin
                    n_hit     = 1'b1;
                    n_hit_idx = scan_idx;
                    n_state   = kcst_pkg::BK_EXEC;
                end else begin
                    // remember the lowest empty slot seen
                    if (scan_key == '0 && !r_free) begin
                        n_free     = 1'b1;
                        n_free_idx = scan_idx;
                    end
                    n_cnt = r_cnt + 1'b1;
                end
            end

            kcst_pkg::BK_EXEC: begin
                n_out_valid = 1'b1;
                n_status    = kcst_pkg::ST_MISS;
                n_rval      = '0;
                n_state     = kcst_pkg::BK_IDLE;
                if (r_cur.cmd == kcst_pkg::CMD_SET) begin
                    if (r_hit || r_free) begin
                        wr_en    = 1'b1;
                        wr_key   = r_cur.key;
                        wr_val   = r_cur.wval;
                        n_status = kcst_pkg::ST_OK;
                    end
                end else if (r_hit) begin
                    n_rval   = r_slot_value[r_hit_idx];
                    n_status = kcst_pkg::ST_OK;
                    if (r_cur.cmd == kcst_pkg::CMD_DEL) begin
                        // emptied slot: key and value back to zero
                        wr_en = 1'b1;
                    end
                end
            end

            default: begin
                n_state = kcst_pkg::BK_IDLE;
            end
        endcase
    end

endmodule

>>> hw/rtl/keyed_context_slot_table.sv
// keyed_context_slot_table: top level, configuration register and wiring.
// Instantiates kcst_front, kcst_queue and kcst_back; uses kcst_pkg.

// Fully associative table of eight 64-bit key/value slots (zero key = empty).
// A request is taken when start is high and busy is low; exactly one result
// follows per request, in order, as a one-cycle strobe on o_result_valid with
// o_status and o_read_value. The receiver cannot stall results. A request whose
// key is zero or whose command is unused answers with ST_BAD without a scan.
// Any other request waits for the scan of the active slots (the active slot count
// saturated at 8): the back end scans the slot store one slot per cycle and
// stops early on a key match. Up to two classified requests wait in the queue
// ahead of the scanner, and busy rises once the front register and the queue
// are full. Slot keys are cleared by reset, which empties every slot.
// Write active_slots only while no request is in flight; o_cfg_ready stays high.
module keyed_context_slot_table (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [kcst_pkg::CMD_W-1:0]  i_cmd,
    input  logic [kcst_pkg::KEY_W-1:0]  i_key,
    input  logic [kcst_pkg::VAL_W-1:0]  i_write_value,
    output logic                        o_result_valid,
    output logic [kcst_pkg::STAT_W-1:0] o_status,
    output logic [kcst_pkg::VAL_W-1:0]  o_read_value,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [kcst_pkg::CFG_W-1:0]  i_cfg_data
);

    logic [kcst_pkg::CFG_W-1:0] r_active;
    logic                       q_push;
    logic                       q_full;
    logic                       q_pop;
    logic                       q_empty;
    kcst_pkg::t_item            q_in;
    kcst_pkg::t_item            q_out;

    assign o_cfg_ready = 1'b1;

    // active slot count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= kcst_pkg::ACTIVE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_active <= i_cfg_data;
        end
    end

    kcst_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .i_key         (i_key),
        .i_write_value (i_write_value),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_data      (q_in)
    );

    kcst_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_in),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_pop_data  (q_out),
        .o_empty     (q_empty)
    );

    kcst_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_active       (r_active),
        .i_q_empty      (q_empty),
        .i_q_data       (q_out),
        .o_q_pop        (q_pop),
        .o_result_valid (o_result_valid),
        .o_status       (o_status),
        .o_read_value   (o_read_value)
    );

endmodule
